FILE: hdl/ethernet_header_classifier_defines.svh
// ----------------------------------------------------------------------------
// Ethernet header classifier - assertion macros
// Shared property shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_HEADER_CLASSIFIER_DEFINES_SVH
`define ETHERNET_HEADER_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define EHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ehc_pkg.sv
// ----------------------------------------------------------------------------
// Ethernet header classifier - package
// Capture window, header byte offsets, class codes and shared types.
// ----------------------------------------------------------------------------
package ehc_pkg;

	// capture window: frame bytes CapFirst .. CapEnd-1
	localparam int unsigned CapFirst = 12;
	localparam int unsigned CapEnd   = 58;
	localparam int unsigned CapLen   = CapEnd - CapFirst;
	localparam int unsigned PosW     = $clog2(CapEnd + 1);
	localparam int unsigned IdxW     = $clog2(CapLen);

	localparam int unsigned ClsW  = 5;
	localparam int unsigned KindW = 2;
	localparam int unsigned AddrW = 64;

	// element 0 is frame byte CapFirst; ascending so a slice reads big-endian
	typedef logic [0:CapLen-1][7:0] hdr_t;
	typedef logic [ClsW-1:0]        cls_t;
	typedef logic [KindW-1:0]       kind_t;
	typedef logic [AddrW-1:0]       addr_t;

	// protocol classes
	localparam cls_t ClsNone   = 5'd0;
	localparam cls_t ClsArp    = 5'd1;
	localparam cls_t ClsIpv4   = 5'd2;
	localparam cls_t ClsIpv6   = 5'd3;
	localparam cls_t ClsTcp    = 5'd4;
	localparam cls_t ClsUdp    = 5'd5;
	localparam cls_t ClsIcmp   = 5'd6;
	localparam cls_t ClsIgmp   = 5'd7;
	localparam cls_t ClsHttp   = 5'd8;
	localparam cls_t ClsFtpCtl = 5'd9;
	localparam cls_t ClsFtpDat = 5'd10;
	localparam cls_t ClsSsh    = 5'd11;
	localparam cls_t ClsDns    = 5'd12;
	localparam cls_t ClsSmtp   = 5'd13;
	localparam cls_t ClsPop3   = 5'd14;
	localparam cls_t ClsHttps  = 5'd15;
	localparam cls_t ClsTelnet = 5'd16;

	// address kinds
	localparam kind_t KindNone = 2'd0;
	localparam kind_t KindIpv4 = 2'd1;
	localparam kind_t KindIpv6 = 2'd2;

endpackage

FILE: hdl/ehc_intf.sv
// ----------------------------------------------------------------------------
// Ethernet header classifier - channel interfaces
// Valid/ready channels for frame bytes in and classification results out.
// ----------------------------------------------------------------------------
interface ehc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface ehc_out_if import ehc_pkg::*;;
	logic  valid;
	logic  ready;
	cls_t  protocol_class;
	kind_t address_kind;
	addr_t source_high;
	addr_t source_low;
	addr_t dest_high;
	addr_t dest_low;

	modport source (output valid, output protocol_class, output address_kind,
		output source_high, output source_low, output dest_high, output dest_low,
		input ready);
	modport sink (input valid, input protocol_class, input address_kind,
		input source_high, input source_low, input dest_high, input dest_low,
		output ready);
endinterface

FILE: hdl/ehc_capture.sv
// ----------------------------------------------------------------------------
// Ethernet header classifier - header capture
// Counts frame bytes, keeps bytes 12..57 and flags a finished frame.
// ----------------------------------------------------------------------------
module ehc_capture import ehc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ehc_in_if.sink frame,
	input  logic advance,
	output logic pending,
	output hdr_t hdr
);

	logic [PosW-1:0] pos_q;
	logic            pend_q;
	logic [7:0]      store_q [CapLen];
	logic [CapLen-1:0] vld_q;
	logic            accept;
	logic            in_win;
	logic [IdxW-1:0] widx;

	assign frame.ready = !pend_q || advance;
	assign accept      = frame.valid && frame.ready;
	assign in_win      = (pos_q >= PosW'(CapFirst)) && (pos_q < PosW'(CapEnd));
	assign widx        = IdxW'(pos_q - PosW'(CapFirst));
	assign pending     = pend_q;

	always_ff @(posedge clk) begin
		if (accept && in_win) begin
			store_q[widx] <= frame.data_byte;
		end
	end

	// drop the whole capture once the frame result is loaded into the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (advance) begin
				vld_q <= '0;
			end
			if (accept && in_win) begin
				vld_q[widx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if (accept) begin
				if (frame.frame_end) begin
					pos_q <= '0;
				end else if (pos_q < PosW'(CapEnd)) begin
					pos_q <= pos_q + PosW'(1);
				end
			end
			if (accept && frame.frame_end) begin
				pend_q <= 1'b1;
			end else if (advance) begin
				pend_q <= 1'b0;
			end
		end
	end

	// bytes not received read as zero
	always_comb begin
		for (int k = 0; k < CapLen; k++) begin
			hdr[k] = vld_q[k] ? store_q[k] : 8'h00;
		end
	end

endmodule

FILE: hdl/ehc_classify.sv
// ----------------------------------------------------------------------------
// Ethernet header classifier - classification and result register
// Decodes the captured header into class and addresses, holds the result.
// ----------------------------------------------------------------------------
module ehc_classify import ehc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  hdr_t hdr,
	input  logic pending,
	output logic advance,
	ehc_out_if.source result
);

	// header offsets, relative to the capture window
	localparam int unsigned OEtype  = 12 - CapFirst;
	localparam int unsigned OVer    = 14 - CapFirst;
	localparam int unsigned O6Next  = 20 - CapFirst;
	localparam int unsigned O4Proto = 23 - CapFirst;
	localparam int unsigned OArpSrc = 28 - CapFirst;
	localparam int unsigned OArpDst = 38 - CapFirst;
	localparam int unsigned O4Src   = 26 - CapFirst;
	localparam int unsigned O4Dst   = 30 - CapFirst;
	localparam int unsigned O4Port  = 34 - CapFirst;
	localparam int unsigned O6SrcHi = 22 - CapFirst;
	localparam int unsigned O6SrcLo = 30 - CapFirst;
	localparam int unsigned O6DstHi = 38 - CapFirst;
	localparam int unsigned O6DstLo = 46 - CapFirst;
	localparam int unsigned O6Port  = 54 - CapFirst;

	localparam logic [15:0] EtArp   = 16'h0806;
	localparam logic [15:0] EtIpv4  = 16'h0800;
	localparam logic [15:0] EtIpv6  = 16'h86dd;
	localparam logic [3:0]  Ver4    = 4'd4;
	localparam logic [3:0]  Ver6    = 4'd6;
	localparam logic [7:0]  ProtoIcmp = 8'd1;
	localparam logic [7:0]  ProtoIgmp = 8'd2;
	localparam logic [7:0]  ProtoTcp  = 8'd6;
	localparam logic [7:0]  ProtoUdp  = 8'd17;

	localparam logic [15:0] PortHttp   = 16'd80;
	localparam logic [15:0] PortFtpCtl = 16'd21;
	localparam logic [15:0] PortFtpDat = 16'd20;
	localparam logic [15:0] PortSsh    = 16'd22;
	localparam logic [15:0] PortDns    = 16'd53;
	localparam logic [15:0] PortSmtp   = 16'd25;
	localparam logic [15:0] PortPop3   = 16'd110;
	localparam logic [15:0] PortHttps  = 16'd443;
	localparam logic [15:0] PortTelnet = 16'd23;

	function automatic cls_t l4_class(input logic [7:0] proto, input logic [15:0] sp,
		input logic [15:0] dp, input cls_t fallback);
		cls_t c;
		c = fallback;
		priority if (proto == ProtoTcp) begin
			// well-known ports in priority order
			priority if (sp == PortHttp   || dp == PortHttp)   c = ClsHttp;
			else if     (sp == PortFtpCtl || dp == PortFtpCtl) c = ClsFtpCtl;
			else if     (sp == PortFtpDat || dp == PortFtpDat) c = ClsFtpDat;
			else if     (sp == PortSsh    || dp == PortSsh)    c = ClsSsh;
			else if     (sp == PortDns    || dp == PortDns)    c = ClsDns;
			else if     (sp == PortSmtp   || dp == PortSmtp)   c = ClsSmtp;
			else if     (sp == PortPop3   || dp == PortPop3)   c = ClsPop3;
			else if     (sp == PortHttps  || dp == PortHttps)  c = ClsHttps;
			else if     (sp == PortTelnet || dp == PortTelnet) c = ClsTelnet;
			else                                               c = ClsTcp;
		end else if (proto == ProtoUdp) begin
			c = (sp == PortDns || dp == PortDns) ? ClsDns : ClsUdp;
		end else if (proto == ProtoIcmp) begin
			c = ClsIcmp;
		end else if (proto == ProtoIgmp) begin
			c = ClsIgmp;
		end else begin
			c = fallback;
		end
		return c;
	endfunction

	logic [15:0] et;
	logic [3:0]  ver;
	cls_t        cls_d;
	kind_t       kind_d;
	addr_t       sh_d, sl_d, dh_d, dl_d;

	logic        vld_q;
	cls_t        cls_q;
	kind_t       kind_q;
	addr_t       sh_q, sl_q, dh_q, dl_q;

	assign et  = hdr[OEtype +: 2];
	assign ver = hdr[OVer][7:4];

	always_comb begin
		cls_d  = ClsNone;
		kind_d = KindNone;
		sh_d   = '0;
		sl_d   = '0;
		dh_d   = '0;
		dl_d   = '0;
		priority if (et == EtArp) begin
			cls_d  = ClsArp;
			kind_d = KindIpv4;
			sl_d   = AddrW'(hdr[OArpSrc +: 4]);
			dl_d   = AddrW'(hdr[OArpDst +: 4]);
		end else if (et == EtIpv4 && ver == Ver4) begin
			cls_d  = l4_class(hdr[O4Proto], hdr[O4Port +: 2], hdr[O4Port + 2 +: 2], ClsIpv4);
			kind_d = KindIpv4;
			sl_d   = AddrW'(hdr[O4Src +: 4]);
			dl_d   = AddrW'(hdr[O4Dst +: 4]);
		end else if ((et == EtIpv4 && ver == Ver6) || et == EtIpv6) begin
			cls_d  = l4_class(hdr[O6Next], hdr[O6Port +: 2], hdr[O6Port + 2 +: 2], ClsIpv6);
			kind_d = KindIpv6;
			sh_d   = hdr[O6SrcHi +: 8];
			sl_d   = hdr[O6SrcLo +: 8];
			dh_d   = hdr[O6DstHi +: 8];
			dl_d   = hdr[O6DstLo +: 8];
		end else begin
			cls_d  = ClsNone;
		end
	end

	// load when the result slot is empty or being drained
	assign advance = pending && (!vld_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= 1'b1;
		end else if (result.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_q  <= cls_d;
			kind_q <= kind_d;
			sh_q   <= sh_d;
			sl_q   <= sl_d;
			dh_q   <= dh_d;
			dl_q   <= dl_d;
		end
	end

	assign result.valid          = vld_q;
	assign result.protocol_class = cls_q;
	assign result.address_kind   = kind_q;
	assign result.source_high    = sh_q;
	assign result.source_low     = sl_q;
	assign result.dest_high      = dh_q;
	assign result.dest_low       = dl_q;

endmodule

FILE: hdl/ethernet_header_classifier.sv
// ----------------------------------------------------------------------------
// Ethernet header classifier - top level
// Byte-wide frame in, one protocol class and address result per frame out.
// ----------------------------------------------------------------------------
//  channel  | side   | item
//  ---------+--------+----------------------------------------------------
//  frame    | sink   | data_byte, frame_end (one frame byte)
//  result   | source | protocol_class, address_kind, source/dest high/low
//
// One byte is taken every cycle while frame.ready is high; a frame's result
// goes via pending into a single result register behind the capture registers.
// Reset clears the byte counter, the capture valid bits and the result slot.
// frame.ready drops only while a finished frame waits for the result slot,
// i.e. when the previous result is still held by result.ready low.
// ----------------------------------------------------------------------------
`include "ethernet_header_classifier_defines.svh"

module ethernet_header_classifier import ehc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ehc_in_if.sink   frame,
	ehc_out_if.source result
);

	logic pending;
	logic advance;
	hdr_t hdr;

	ehc_capture u_capture (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame),
		.advance (advance),
		.pending (pending),
		.hdr     (hdr)
	);

	ehc_classify u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.hdr     (hdr),
		.pending (pending),
		.advance (advance),
		.result  (result)
	);

	`EHC_ASSERT_NEXT(a_end_flags_pending, frame.valid && frame.ready && frame.frame_end, pending, "frame end did not raise pending")
	`EHC_ASSERT_NEXT(a_advance_shows, advance, result.valid, "result not presented after load")
	`EHC_ASSERT_NOW(a_stall_blocks_in, pending && !advance, !frame.ready, "input taken while result blocked")
	`EHC_ASSERT_NOW(a_advance_needs_pending, advance, pending, "result loaded without a finished frame")

endmodule

FILE: tb/tb_ethernet_header_classifier.sv
// ----------------------------------------------------------------------------
// Ethernet header classifier - testbench
// Streams frames byte by byte into the classifier with random input gaps and
// random result backpressure, including one long result hold that stalls the
// byte input. An in-bench model of the header capture predicts the class and
// addresses of every frame; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_ethernet_header_classifier import ehc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FrameMax   = 72;
	localparam int unsigned CycleLimit = 600000;
	localparam int unsigned HoldCycles = 2000;
	localparam int unsigned HoldAfter  = 12;

	// header offsets in frame bytes
	localparam int unsigned OffEtherType = 12;
	localparam int unsigned OffVersion   = 14;
	localparam int unsigned OffV6Next    = 20;
	localparam int unsigned OffV6Src     = 22;
	localparam int unsigned OffV4Proto   = 23;
	localparam int unsigned OffV4Src     = 26;
	localparam int unsigned OffArpSrc    = 28;
	localparam int unsigned OffV4Dst     = 30;
	localparam int unsigned OffV4Ports   = 34;
	localparam int unsigned OffArpDst    = 38;
	localparam int unsigned OffV6Dst     = 38;
	localparam int unsigned OffV6Ports   = 54;

	// shortest frame that still carries both IPv4 ports
	localparam int unsigned V4Len = OffV4Ports + 4;

	localparam logic [15:0] EtherIpv4     = 16'h0800;
	localparam logic [15:0] EtherArp      = 16'h0806;
	localparam logic [15:0] EtherIpv6     = 16'h86dd;
	localparam logic [15:0] EtherIpv6Typo = 16'h80dd;
	localparam logic [3:0]  IpVer4        = 4'd4;
	localparam logic [3:0]  IpVer6        = 4'd6;
	localparam logic [7:0]  ProtoIcmp     = 8'd1;
	localparam logic [7:0]  ProtoIgmp     = 8'd2;
	localparam logic [7:0]  ProtoTcp      = 8'd6;
	localparam logic [7:0]  ProtoUdp      = 8'd17;
	localparam logic [15:0] PortDns       = 16'd53;

	// TCP ports in match priority order, with the class each one gives
	localparam logic [15:0] WellKnownPorts [0:8] = '{16'd80, 16'd21, 16'd20, 16'd22,
		16'd53, 16'd25, 16'd110, 16'd443, 16'd23};
	localparam cls_t PortClasses [0:8] = '{ClsHttp, ClsFtpCtl, ClsFtpDat, ClsSsh,
		ClsDns, ClsSmtp, ClsPop3, ClsHttps, ClsTelnet};

	typedef enum int unsigned {PaceSteady, PaceSparse, PaceRough} pace_t;

	typedef struct {
		logic [7:0]  data_byte;
		logic        frame_end;
		int unsigned gap;
	} frame_byte_t;

	typedef struct packed {
		cls_t  cls;
		kind_t kind;
		addr_t src_hi;
		addr_t src_lo;
		addr_t dst_hi;
		addr_t dst_lo;
	} verdict_t;

	logic clk;
	logic arst_n;

	ehc_in_if  frame_if ();
	ehc_out_if result_if ();

	ethernet_header_classifier u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_if),
		.result (result_if)
	);

	frame_byte_t byte_queue [$];
	verdict_t    expected_results [$];

	// header capture copy
	logic [7:0]  cap_bytes [0:CapLen-1];
	int unsigned cap_pos;

	logic [7:0]  fbuf [0:FrameMax-1];
	int unsigned bytes_queued;
	int unsigned frames_queued;

	frame_byte_t next_item;
	bit          have_next;
	int unsigned gap_left;

	int unsigned stall_left;
	bit          eager;
	int unsigned hold_left;
	bit          hold_done;
	int unsigned results_seen;
	int unsigned bytes_seen;
	int unsigned frames_seen;
	int unsigned input_stalls;
	int unsigned errors;
	int unsigned class_hits [0:16];
	int unsigned cycle_count;

	// ------------------------------------------------------------------
	// header classification model
	// ------------------------------------------------------------------
	function automatic logic [7:0] hdr_at(int unsigned off);
		if (off < CapFirst || off >= CapEnd) return 8'h00;
		return cap_bytes[off - CapFirst];
	endfunction

	function automatic addr_t hdr_span(int unsigned off, int unsigned count);
		addr_t v;
		v = '0;
		for (int unsigned i = 0; i < count; i++) v = {v[AddrW-9:0], hdr_at(off + i)};
		return v;
	endfunction

	function automatic cls_t port_class(logic [7:0] proto, int unsigned off, cls_t fallback);
		logic [15:0] sport;
		logic [15:0] dport;
		cls_t        c;
		sport = {hdr_at(off), hdr_at(off + 1)};
		dport = {hdr_at(off + 2), hdr_at(off + 3)};
		c = fallback;
		if (proto == ProtoTcp) begin
			c = ClsTcp;
			// walk backwards so the highest-priority match wins
			for (int i = 8; i >= 0; i--)
				if (sport == WellKnownPorts[i] || dport == WellKnownPorts[i]) c = PortClasses[i];
		end else if (proto == ProtoUdp) begin
			c = (sport == PortDns || dport == PortDns) ? ClsDns : ClsUdp;
		end else if (proto == ProtoIcmp) begin
			c = ClsIcmp;
		end else if (proto == ProtoIgmp) begin
			c = ClsIgmp;
		end
		return c;
	endfunction

	function automatic void absorb_byte(logic [7:0] b, logic last);
		verdict_t    v;
		logic [15:0] etype;
		logic [7:0]  vbyte;
		logic [3:0]  ver;
		if (cap_pos >= CapFirst && cap_pos < CapEnd) cap_bytes[cap_pos - CapFirst] = b;
		if (cap_pos < CapEnd) cap_pos++;
		bytes_seen++;
		if (!last) return;

		v = '0;
		etype = {hdr_at(OffEtherType), hdr_at(OffEtherType + 1)};
		vbyte = hdr_at(OffVersion);
		ver = vbyte[7:4];
		if (etype == EtherArp) begin
			v.cls = ClsArp;
			v.kind = KindIpv4;
			v.src_lo = hdr_span(OffArpSrc, 4);
			v.dst_lo = hdr_span(OffArpDst, 4);
		end else if (etype == EtherIpv4 && ver == IpVer4) begin
			v.cls = port_class(hdr_at(OffV4Proto), OffV4Ports, ClsIpv4);
			v.kind = KindIpv4;
			v.src_lo = hdr_span(OffV4Src, 4);
			v.dst_lo = hdr_span(OffV4Dst, 4);
		end else if ((etype == EtherIpv4 && ver == IpVer6) || etype == EtherIpv6) begin
			v.cls = port_class(hdr_at(OffV6Next), OffV6Ports, ClsIpv6);
			v.kind = KindIpv6;
			v.src_hi = hdr_span(OffV6Src, 8);
			v.src_lo = hdr_span(OffV6Src + 8, 8);
			v.dst_hi = hdr_span(OffV6Dst, 8);
			v.dst_lo = hdr_span(OffV6Dst + 8, 8);
		end
		expected_results.push_back(v);
		class_hits[v.cls]++;
		frames_seen++;

		// start the next frame clean
		cap_pos = 0;
		foreach (cap_bytes[i]) cap_bytes[i] = 8'h00;
	endfunction

	function automatic void check_result();
		verdict_t got;
		verdict_t want;
		got.cls    = result_if.protocol_class;
		got.kind   = result_if.address_kind;
		got.src_hi = result_if.source_high;
		got.src_lo = result_if.source_low;
		got.dst_hi = result_if.dest_high;
		got.dst_lo = result_if.dest_low;
		if (expected_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: class %0d kind %0d", got.cls, got.kind);
			return;
		end
		want = expected_results.pop_front();
		if (got.cls !== want.cls || got.kind !== want.kind || got.src_hi !== want.src_hi
				|| got.src_lo !== want.src_lo || got.dst_hi !== want.dst_hi
				|| got.dst_lo !== want.dst_lo) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch at result %0d: class exp %0d got %0d, kind exp %0d got %0d",
					results_seen, want.cls, got.cls, want.kind, got.kind);
				$display("  src exp %h_%h got %h_%h", want.src_hi, want.src_lo,
					got.src_hi, got.src_lo);
				$display("  dst exp %h_%h got %h_%h", want.dst_hi, want.dst_lo,
					got.dst_hi, got.dst_lo);
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// frame construction
	// ------------------------------------------------------------------
	function automatic void fill_frame(bit scramble, logic [7:0] val);
		for (int unsigned i = 0; i < FrameMax; i++)
			fbuf[i] = scramble ? 8'($urandom_range(0, 255)) : val;
	endfunction

	function automatic void put_word(int unsigned off, logic [15:0] w);
		fbuf[off]     = w[15:8];
		fbuf[off + 1] = w[7:0];
	endfunction

	// random body; protocol and ports land where the ethertype/version path reads them
	function automatic void shape_ip(logic [15:0] etype, logic [3:0] ver, logic [7:0] proto,
			logic [15:0] sport, logic [15:0] dport);
		logic [3:0] low_nibble;
		low_nibble = 4'($urandom_range(0, 15));
		fill_frame(1'b1, 8'h00);
		put_word(OffEtherType, etype);
		fbuf[OffVersion] = {ver, low_nibble};
		if (etype == EtherIpv4 && ver == IpVer4) begin
			fbuf[OffV4Proto] = proto;
			put_word(OffV4Ports, sport);
			put_word(OffV4Ports + 2, dport);
		end else begin
			fbuf[OffV6Next] = proto;
			put_word(OffV6Ports, sport);
			put_word(OffV6Ports + 2, dport);
		end
	endfunction

	function automatic void queue_frame(int unsigned len);
		pace_t       pace;
		frame_byte_t fb;
		pace = pace_t'($urandom_range(0, 2));
		for (int unsigned i = 0; i < len; i++) begin
			fb.data_byte = fbuf[i];
			fb.frame_end = (i == len - 1);
			case (pace)
				PaceSteady: fb.gap = 0;
				PaceSparse: fb.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
				default:    fb.gap = $urandom_range(0, 14);
			endcase
			byte_queue.push_back(fb);
		end
		bytes_queued += len;
		frames_queued++;
	endfunction

	// mostly well-formed headers with random content, some noise
	function automatic int unsigned random_frame();
		int unsigned pick;
		int unsigned len;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  proto;
		logic [3:0]  ver;
		pick  = $urandom_range(0, 99);
		sport = 16'($urandom_range(0, 65535));
		dport = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 4))
			0:       proto = ProtoTcp;
			1:       proto = ProtoUdp;
			2:       proto = ProtoIcmp;
			3:       proto = ProtoIgmp;
			default: proto = 8'($urandom_range(0, 255));
		endcase
		if ($urandom_range(0, 3) != 0) begin
			if ($urandom_range(0, 1) == 1) sport = WellKnownPorts[$urandom_range(0, 8)];
			else dport = WellKnownPorts[$urandom_range(0, 8)];
			if ($urandom_range(0, 3) == 0) begin
				sport = WellKnownPorts[$urandom_range(0, 8)];
				dport = WellKnownPorts[$urandom_range(0, 8)];
			end
		end

		if (pick < 15) begin
			fill_frame(1'b1, 8'h00);
		end else if (pick < 30) begin
			fill_frame(1'b1, 8'h00);
			put_word(OffEtherType, EtherArp);
		end else if (pick < 55) begin
			shape_ip(EtherIpv4, IpVer4, proto, sport, dport);
		end else if (pick < 70) begin
			shape_ip(EtherIpv4, IpVer6, proto, sport, dport);
		end else if (pick < 85) begin
			shape_ip(EtherIpv6, 4'($urandom_range(0, 15)), proto, sport, dport);
		end else if (pick < 90) begin
			shape_ip(EtherIpv6Typo, IpVer6, proto, sport, dport);
		end else if (pick < 95) begin
			do ver = 4'($urandom_range(0, 15)); while (ver == IpVer4 || ver == IpVer6);
			shape_ip(EtherIpv4, ver, proto, sport, dport);
		end else begin
			shape_ip(16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)), proto, sport,
				dport);
		end

		pick = $urandom_range(0, 9);
		if (pick < 2) len = $urandom_range(1, CapEnd - 1);
		else if (pick < 4) len = $urandom_range(CapEnd + 1, FrameMax);
		else len = CapEnd;
		return len;
	endfunction

	// ------------------------------------------------------------------
	// clock, reset, stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int unsigned distinct;
		frame_if.valid     = 1'b0;
		frame_if.data_byte = 8'h00;
		frame_if.frame_end = 1'b0;
		result_if.ready    = 1'b0;
		arst_n = 1'b0;

		// directed frames
		fill_frame(1'b0, 8'hff);
		queue_frame(1);
		fill_frame(1'b0, 8'h00);
		queue_frame(CapEnd);
		fill_frame(1'b1, 8'h00);
		put_word(OffEtherType, EtherArp);
		queue_frame(CapEnd);
		for (int i = 0; i < 9; i++) begin
			if (i % 2 == 1) shape_ip(EtherIpv4, IpVer4, ProtoTcp, 16'hc000, WellKnownPorts[i]);
			else shape_ip(EtherIpv4, IpVer4, ProtoTcp, WellKnownPorts[i], 16'hc001);
			queue_frame(V4Len);
		end
		shape_ip(EtherIpv4, IpVer4, ProtoTcp, 16'd443, 16'd80);
		queue_frame(V4Len);
		shape_ip(EtherIpv4, IpVer4, ProtoTcp, 16'h1234, 16'hffff);
		queue_frame(V4Len);
		shape_ip(EtherIpv4, IpVer4, ProtoUdp, 16'h0000, PortDns);
		queue_frame(V4Len);
		shape_ip(EtherIpv4, IpVer4, ProtoUdp, 16'hffff, 16'h0000);
		queue_frame(V4Len);
		shape_ip(EtherIpv4, IpVer4, ProtoIcmp, 16'h0000, 16'h0000);
		queue_frame(V4Len);
		shape_ip(EtherIpv4, IpVer4, ProtoIgmp, 16'h0000, 16'h0000);
		queue_frame(V4Len);
		shape_ip(EtherIpv6, IpVer6, ProtoTcp, WellKnownPorts[3], 16'hffff);
		queue_frame(CapEnd);
		shape_ip(EtherIpv4, IpVer6, ProtoUdp, PortDns, 16'h0000);
		queue_frame(CapEnd);
		shape_ip(EtherIpv6Typo, IpVer6, ProtoTcp, 16'd80, 16'd80);
		queue_frame(CapEnd);
		shape_ip(EtherIpv4, 4'd5, ProtoTcp, 16'd80, 16'd80);
		queue_frame(V4Len);
		// cut inside the source port: the missing byte reads as zero
		shape_ip(EtherIpv4, IpVer4, ProtoTcp, 16'd80, 16'd443);
		queue_frame(OffV4Ports + 1);
		// long frame: trailing bytes must not disturb the capture
		shape_ip(EtherIpv6, IpVer6, ProtoTcp, 16'hffff, 16'd23);
		queue_frame(FrameMax);

		// random frames
		begin
			int unsigned base_bytes;
			int unsigned base_frames;
			base_bytes  = bytes_queued;
			base_frames = frames_queued;
			while (bytes_queued - base_bytes < 200 || frames_queued - base_frames < 4)
				queue_frame(random_frame());
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || have_next || frame_if.valid) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		distinct = 0;
		foreach (class_hits[i]) if (class_hits[i] != 0) distinct++;
		$display("ran %0d frames (%0d bytes), %0d of 17 protocol classes hit", frames_seen,
			bytes_seen, distinct);
		$display("byte input held off for %0d cycles; %0d errors", input_stalls, errors);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d results never arrived", expected_results.size());
			$display("tb: failure");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// byte driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_if.valid     <= 1'b0;
			frame_if.data_byte <= 8'h00;
			frame_if.frame_end <= 1'b0;
			have_next = 1'b0;
			gap_left  = 0;
		end else if (!frame_if.valid || frame_if.ready) begin
			if (!have_next && byte_queue.size() != 0) begin
				next_item = byte_queue.pop_front();
				have_next = 1'b1;
				gap_left  = next_item.gap;
			end
			if (have_next && gap_left == 0) begin
				frame_if.valid     <= 1'b1;
				frame_if.data_byte <= next_item.data_byte;
				frame_if.frame_end <= next_item.frame_end;
				have_next = 1'b0;
			end else begin
				frame_if.valid <= 1'b0;
				if (have_next) gap_left--;
			end
		end
	end

	// ------------------------------------------------------------------
	// long result hold, counted on its own
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen == HoldAfter) begin
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict from accepted bytes, then check accepted results
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			results_seen    <= 0;
			stall_left = 0;
			eager      = 1'b0;
			cap_pos    = 0;
			foreach (cap_bytes[i]) cap_bytes[i] = 8'h00;
		end else begin
			if (frame_if.valid && frame_if.ready)
				absorb_byte(frame_if.data_byte, frame_if.frame_end);
			if (frame_if.valid && !frame_if.ready) input_stalls++;
			if (result_if.valid && result_if.ready) begin
				check_result();
				results_seen <= results_seen + 1;
				if ($urandom_range(0, 15) == 0) eager = !eager;
				stall_left = eager ? 0 : $urandom_range(0, 14);
			end
			if (hold_left > 0) begin
				result_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

endmodule

FILE: ethernet_header_classifier.f
+incdir+hdl
hdl/ehc_pkg.sv
hdl/ehc_intf.sv
hdl/ehc_capture.sv
hdl/ehc_classify.sv
hdl/ethernet_header_classifier.sv
tb/tb_ethernet_header_classifier.sv
